// ===== rtl/dfe_pkg.sv =====
// Shared types and constants for the decimal factorial engine.
// No dependencies; imported by dfe_digit_mac and decimal_factorial_engine.
`timescale 1ns / 1ps
`default_nettype none

package dfe_pkg;

   typedef logic [3:0] digit_type;
   typedef logic [1:0] status_type;

   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_NEGATIVE  = 2'd1;
   localparam status_type STATUS_TOO_LARGE = 2'd2;

   localparam int ARG_W        = 8;
   localparam int LIMIT_W      = 5;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd30;

   // Most digits handed out per argument; the most significant ones are kept.
   localparam int RESULT_CAP   = 33;

   localparam int DIGIT_BASE   = 10;

   // x / 10 == (x * 205) >> 11 for every x below 1029.
   localparam int RECIP10_MUL  = 205;
   localparam int RECIP10_SHR  = 11;

endpackage

`default_nettype wire

// ===== rtl/dfe_digit_mac.sv =====
// One digit step of the multiply pass: digit * multiplier + carry, split in base ten.
// Depends on dfe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dfe_digit_mac #(
   parameter int MAX_ARG = 30
) (
   input  wire dfe_pkg::digit_type            digit,
   input  wire [$clog2(MAX_ARG+1)-1:0]        multiplier,
   input  wire [$clog2(MAX_ARG+1)-1:0]        carry,
   output dfe_pkg::digit_type                 sum_digit,
   output logic [$clog2(MAX_ARG+1)-1:0]       sum_carry
);
   import dfe_pkg::*;

   localparam int MW = $clog2(MAX_ARG + 1);
   // carry never exceeds the multiplier, so the sum stays below 10 * MAX_ARG + 1
   localparam int TW = ($clog2(10 * MAX_ARG + 1) < 4) ? 4 : $clog2(10 * MAX_ARG + 1);
   localparam int PW = TW + 8;

   logic [TW-1:0] total;
   logic [PW-1:0] recip_prod;
   logic [MW-1:0] quot;
   logic [TW-1:0] rem_w;

   always_comb begin
      total      = TW'(digit) * TW'(multiplier) + TW'(carry);
      recip_prod = PW'(total) * PW'(RECIP10_MUL);
      quot       = MW'(recip_prod >> RECIP10_SHR);
      rem_w      = total - TW'(quot) * TW'(DIGIT_BASE);
   end

   assign sum_digit = digit_type'(rem_w[3:0]);
   assign sum_carry = quot;

endmodule

`default_nettype wire

// ===== rtl/decimal_factorial_engine.sv =====
// Decimal factorial engine: top level with digit store and pass sequencer.
// Each pass m=2..N multiplies the whole digit store by m, then appends the carry digits;
// each pass walks the digit store one digit per cycle.
// One argument at a time: busy stays high from accept until the last beat is shown.
// Rejected arguments are answered straight from the screening state. The receiver cannot stall rsp beats.
// Reset is synchronous: control and the limit register (30) clear; the store is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module decimal_factorial_engine #(
   parameter int MAX_ARG    = 30,
   parameter int MAX_DIGITS = 64
) (
   input  wire                         clock,
   input  wire                         reset,
   // request side
   input  wire                         start,
   output logic                        busy,
   input  wire signed [7:0]            req_argument,
   // result side
   output logic                        rsp_valid,
   output dfe_pkg::digit_type          rsp_digit,
   output dfe_pkg::status_type         rsp_status,
   output logic                        rsp_last,
   // limit register write
   input  wire                         csr_valid,
   output logic                        csr_ready,
   input  wire [4:0]                   csr_max_argument
);
   import dfe_pkg::*;

   localparam int MW     = $clog2(MAX_ARG + 1);
   localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
   localparam int ADDR_W = $clog2(MAX_DIGITS);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_INIT = 3'd1;
   localparam logic [2:0] ST_MUL  = 3'd2;
   localparam logic [2:0] ST_APP  = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   // control state
   logic [2:0]          state_ff, state_in;
   logic [LIMIT_W-1:0]  limit_ff, limit_in;
   logic [MW-1:0]       mult_ff, mult_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    idx_ff, idx_in;
   logic [CNT_W-1:0]    first_ff, first_in;
   logic [MW-1:0]       carry_ff, carry_in;
   logic                rv_ff, rv_in;
   logic                tail_ff, tail_in;
   logic                rsp_valid_ff, rsp_valid_in;
   // payload
   logic [ARG_W-1:0]    arg_ff, arg_in;
   logic [ADDR_W-1:0]   wa_ff, wa_in;
   digit_type           rsp_digit_ff, rsp_digit_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic                rsp_last_ff, rsp_last_in;

   // digit store, least significant digit at entry 0
   digit_type           store_mem [MAX_DIGITS];
   digit_type           rd_data_ff;
   logic                mem_re;
   logic [ADDR_W-1:0]   mem_ra;
   logic                mem_we;
   logic [ADDR_W-1:0]   mem_wa;
   digit_type           mem_wd;

   // shared digit step unit
   digit_type           mac_digit;
   digit_type           mac_sum_digit;
   logic [MW-1:0]       mac_sum_carry;

   // scratch
   logic [ARG_W-1:0]    eff_limit;
   logic [ARG_W-1:0]    count_ext;
   logic [CNT_W-1:0]    idx_dec;
   logic                issue;

   dfe_digit_mac #(
      .MAX_ARG    (MAX_ARG)
   ) u_mac (
      .digit      (mac_digit),
      .multiplier (mult_ff),
      .carry      (carry_ff),
      .sum_digit  (mac_sum_digit),
      .sum_carry  (mac_sum_carry)
   );

   // Append phase feeds a zero digit so the unit just splits the carry.
   assign mac_digit = (state_ff == ST_APP) ? digit_type'(4'd0) : rd_data_ff;

   assign busy       = (state_ff != ST_IDLE);
   assign csr_ready  = 1'b1;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_digit  = rsp_digit_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_last   = rsp_last_ff;

   // Saturate the effective limit at the build-time maximum.
   assign eff_limit = (ARG_W'(limit_ff) > ARG_W'(MAX_ARG)) ? ARG_W'(MAX_ARG) : ARG_W'(limit_ff);
   assign count_ext = ARG_W'(count_ff);
   assign idx_dec   = idx_ff - CNT_W'(1);

   always_comb begin
      state_in      = state_ff;
      limit_in      = limit_ff;
      mult_in       = mult_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      first_in      = first_ff;
      carry_in      = carry_ff;
      rv_in         = 1'b0;
      tail_in       = tail_ff;
      rsp_valid_in  = 1'b0;
      arg_in        = arg_ff;
      wa_in         = wa_ff;
      rsp_digit_in  = rsp_digit_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      mem_re        = 1'b0;
      mem_ra        = idx_ff[ADDR_W-1:0];
      mem_we        = 1'b0;
      mem_wa        = wa_ff;
      mem_wd        = mac_sum_digit;
      issue         = 1'b0;

      // limit register beat; by contract the user writes it only while idle, which the block does not enforce
      if (csr_valid && csr_ready) begin
         limit_in = csr_max_argument;
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               arg_in   = req_argument;
               state_in = ST_INIT;
            end
         end

         ST_INIT: begin
            // Seed the store with the single digit 1, then screen the argument.
            mem_we   = 1'b1;
            mem_wa   = '0;
            mem_wd   = digit_type'(4'd1);
            count_in = CNT_W'(1);
            carry_in = '0;
            idx_in   = '0;
            mult_in  = MW'(2);
            if (arg_ff[ARG_W-1]) begin
               rsp_valid_in  = 1'b1;
               rsp_digit_in  = '0;
               rsp_status_in = STATUS_NEGATIVE;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end else if (arg_ff > eff_limit) begin
               rsp_valid_in  = 1'b1;
               rsp_digit_in  = '0;
               rsp_status_in = STATUS_TOO_LARGE;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end else if (arg_ff < ARG_W'(2)) begin
               // zero or one: emit the seed digit directly
               idx_in   = CNT_W'(1);
               first_in = '0;
               state_in = ST_OUT;
            end else begin
               state_in = ST_MUL;
            end
         end

         ST_MUL: begin
            // Read digit i while writing back digit i-1; addresses never collide.
            issue = (idx_ff < count_ff);
            if (issue) begin
               mem_re = 1'b1;
               mem_ra = idx_ff[ADDR_W-1:0];
               wa_in  = idx_ff[ADDR_W-1:0];
               idx_in = idx_ff + CNT_W'(1);
               rv_in  = 1'b1;
            end
            if (rv_ff) begin
               mem_we   = 1'b1;
               mem_wa   = wa_ff;
               carry_in = mac_sum_carry;
               if (!issue) begin
                  state_in = ST_APP;
               end
            end
         end

         ST_APP: begin
            if (carry_ff != '0) begin
               // Append one carry digit per cycle; drop it once the store is full.
               if (count_ff < CNT_W'(MAX_DIGITS)) begin
                  mem_we   = 1'b1;
                  mem_wa   = count_ff[ADDR_W-1:0];
                  count_in = count_ff + CNT_W'(1);
               end
               carry_in = mac_sum_carry;
            end else if (mult_ff == arg_ff[MW-1:0]) begin
               idx_in   = count_ff;
               first_in = (count_ext > ARG_W'(RESULT_CAP))
                          ? CNT_W'(count_ext - ARG_W'(RESULT_CAP)) : '0;
               state_in = ST_OUT;
            end else begin
               mult_in  = mult_ff + MW'(1);
               idx_in   = '0;
               state_in = ST_MUL;
            end
         end

         ST_OUT: begin
            // Walk down from the top digit; the read data becomes the next beat.
            issue = (idx_ff > first_ff);
            if (issue) begin
               mem_re  = 1'b1;
               mem_ra  = idx_dec[ADDR_W-1:0];
               idx_in  = idx_dec;
               tail_in = (idx_dec == first_ff);
               rv_in   = 1'b1;
            end
            if (rv_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_digit_in  = rd_data_ff;
               rsp_status_in = STATUS_OK;
               rsp_last_in   = tail_ff;
               if (!issue) begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         limit_ff     <= LIMIT_RESET;
         mult_ff      <= '0;
         count_ff     <= '0;
         idx_ff       <= '0;
         first_ff     <= '0;
         carry_ff     <= '0;
         rv_ff        <= 1'b0;
         tail_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         mult_ff      <= mult_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         first_ff     <= first_in;
         carry_ff     <= carry_in;
         rv_ff        <= rv_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      arg_ff        <= arg_in;
      wa_ff         <= wa_in;
      rsp_digit_ff  <= rsp_digit_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // digit store: one write port, one read port with registered data
   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= store_mem[mem_ra];
      end
   end

endmodule

`default_nettype wire
